// ===== rtl/spsa_pkg.sv =====
// ----------------------------------------------------------------------------
// spsa_pkg
// Shared types, constants and a helper function for the sub-page slab
// allocator: status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package spsa_pkg;

	localparam int PAGE_LOG2      = 12;
	localparam int MIN_TABLE_LOG2 = 8;
	localparam int NUM_PAGES_DEF  = 64;
	localparam int NUM_CLS        = PAGE_LOG2 - MIN_TABLE_LOG2;
	localparam int CLS_W          = 2;
	localparam int SLOT_W         = 16;
	localparam int BYTES_W        = 16;
	localparam int PIDX_W         = 6;
	localparam int OFF_W          = 12;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BYPASS   = 3'd1,
		ST_INVALID  = 3'd2,
		ST_NO_PAGES = 3'd3,
		ST_MAP_FULL = 3'd4,
		ST_UNKNOWN  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_FIND,
		S_PICK,
		S_FRD,
		S_FCHK,
		S_UPD,
		S_FIN,
		S_RESP
	} state_t;

	// How the rank sweep treats the other listed pages of the class.
	typedef enum logic {
		UPD_LIST,
		UPD_UNLIST
	} upd_mode_t;

	// What the final commit does to the target page.
	typedef enum logic [1:0] {
		FIN_NEW,
		FIN_FULL,
		FIN_RELIST,
		FIN_RELEASE
	} fin_kind_t;

	typedef struct packed {
		logic load;
		logic check;
		logic find_go;
		logic pick;
		logic frd;
		logic fchk;
		logic upd_go;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic alloc;
		logic go_upd;
		logic scan_done;
	} stat_t;

	// Mask of usable slots for a page of the given class.
	function automatic logic [SLOT_W-1:0] class_mask(input logic [CLS_W-1:0] cls);
		logic [SLOT_W-1:0] m;
		case (cls)
			2'd0:    m = 16'hFFFF;
			2'd1:    m = 16'h00FF;
			2'd2:    m = 16'h000F;
			2'd3:    m = 16'h0003;
			default: m = 16'hFFFF;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/spsa_dp.sv =====
// ----------------------------------------------------------------------------
// spsa_dp
// Datapath: request registers, page flags, page memory with rank sweep,
// slot search and result registers.
// ----------------------------------------------------------------------------
module spsa_dp import spsa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               action,
	input  logic [BYTES_W-1:0] pd_bytes,
	input  logic               is_cached,
	input  logic [PIDX_W-1:0]  page_index,
	input  logic [OFF_W-1:0]   byte_offset_in,
	output logic [2:0]         status,
	output logic [PIDX_W-1:0]  page_out,
	output logic [OFF_W-1:0]   byte_offset_out,
	output logic               page_released
);

	localparam int PG_W = $clog2(NUM_PAGES);
	localparam int CW   = $clog2(NUM_PAGES + 1);
	localparam int IXW  = (PG_W > PIDX_W) ? PG_W : PIDX_W;

	typedef struct packed {
		logic [PG_W-1:0]   rank;
		logic [CLS_W-1:0]  cls;
		logic [SLOT_W-1:0] slot;
	} word_t;

	// Captured request.
	logic               act_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               cached_q;
	logic [PIDX_W-1:0]  pidx_q;
	logic [OFF_W-1:0]   offs_q;

	// Page flags, page memory and sweep state.
	logic [NUM_PAGES-1:0] in_use_q, listed_q;
	word_t                mem [NUM_PAGES];
	word_t                rdata_s1;
	logic                 rd_en;
	logic [PG_W-1:0]      raddr;
	logic                 we;
	logic [PG_W-1:0]      waddr;
	word_t                wdata;

	logic            scan_act_q, scan_find_q, rv_s1;
	logic [CW-1:0]   scan_cnt_q;
	logic [PG_W-1:0] ra_s1;
	logic            issue;

	logic [CLS_W-1:0]  cls_q;
	logic              best_vld_q, free_vld_q;
	logic [PG_W-1:0]   best_q, best_rank_q, free_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [PG_W-1:0]   tgt_q, tgt_rank_q;
	logic              tgt_listed_q;
	logic [SLOT_W-1:0] tgt_slot_q;
	upd_mode_t         mode_q;
	fin_kind_t         fin_q;

	logic [2:0]        res_status_q;
	logic [PIDX_W-1:0] res_page_q;
	logic [OFF_W-1:0]  res_off_q;
	logic              res_rel_q;

	// Request decode.
	logic              bypass_a, invalid_a, unknown_f;
	logic [CLS_W-1:0]  cls_dec;
	logic [IXW-1:0]    pext;
	logic [PG_W-1:0]   pg;

	always_comb begin
		bypass_a  = (bytes_q >> PAGE_LOG2) != '0;
		invalid_a = (bytes_q == '0) || ((bytes_q & (bytes_q - 1'b1)) != '0) ||
			(bytes_q < BYTES_W'(1 << MIN_TABLE_LOG2));
		cls_dec = '0;
		for (int c = 0; c < NUM_CLS; c++) begin
			if (bytes_q == BYTES_W'(1 << (c + MIN_TABLE_LOG2)))
				cls_dec = CLS_W'(c);
		end
		pext      = IXW'(pidx_q);
		pg        = pext[PG_W-1:0];
		unknown_f = ((IXW+1)'(pext) >= (IXW+1)'(NUM_PAGES)) || !in_use_q[pg];
	end

	// Slot search on the chosen partial page.
	logic [SLOT_W-1:0] mask_c, new_slot;
	logic [3:0]        bitn;
	logic              found, slot_ok, now_full;
	logic [SLOT_W-1:0] off_full;

	always_comb begin
		mask_c = class_mask(cls_q);
		bitn   = '0;
		found  = 1'b0;
		for (int i = SLOT_W - 1; i >= 0; i--) begin
			if (!best_slot_q[i]) begin
				bitn  = 4'(i);
				found = 1'b1;
			end
		end
		slot_ok  = found && mask_c[bitn];
		new_slot = best_slot_q | (SLOT_W'(1) << bitn);
		now_full = (new_slot & mask_c) == mask_c;
		off_full = SLOT_W'(bitn) << (5'(cls_q) + 5'(MIN_TABLE_LOG2));
	end

	// Free path: clear the slot bit of the page just read.
	logic [3:0]        fidx;
	logic [SLOT_W-1:0] fslot;
	logic              fkeep;

	always_comb begin
		fidx  = 4'(offs_q >> (5'(rdata_s1.cls) + 5'(MIN_TABLE_LOG2)));
		fslot = rdata_s1.slot & ~(SLOT_W'(1) << fidx);
		fkeep = (fslot & class_mask(rdata_s1.cls)) != '0;
	end

	// Sweep element under inspection.
	logic        same_cls, upd_hit;
	word_t       upd_word;

	always_comb begin
		same_cls = listed_q[ra_s1] && (rdata_s1.cls == cls_q);
		upd_word = rdata_s1;
		upd_hit  = 1'b0;
		if (rv_s1 && !scan_find_q && same_cls && (ra_s1 != tgt_q)) begin
			if (mode_q == UPD_LIST) begin
				if (!tgt_listed_q || (rdata_s1.rank < tgt_rank_q)) begin
					upd_hit       = 1'b1;
					upd_word.rank = rdata_s1.rank + 1'b1;
				end
			end else begin
				if (tgt_listed_q && (rdata_s1.rank > tgt_rank_q)) begin
					upd_hit       = 1'b1;
					upd_word.rank = rdata_s1.rank - 1'b1;
				end
			end
		end
	end

	// Memory read and write port selection.
	always_comb begin
		issue = scan_act_q && (scan_cnt_q != CW'(NUM_PAGES));
		rd_en = issue || cmd.frd;
		raddr = cmd.frd ? pg : scan_cnt_q[PG_W-1:0];
		we    = 1'b0;
		waddr = tgt_q;
		wdata = '{rank: '0, cls: cls_q, slot: tgt_slot_q};
		if (upd_hit) begin
			we    = 1'b1;
			waddr = ra_s1;
			wdata = upd_word;
		end else if (cmd.pick && best_vld_q && slot_ok) begin
			we    = 1'b1;
			waddr = best_q;
			wdata = '{rank: best_rank_q, cls: cls_q, slot: new_slot};
		end else if (cmd.fin && (fin_q == FIN_NEW)) begin
			we    = 1'b1;
			wdata = '{rank: '0, cls: cls_q, slot: SLOT_W'(1)};
		end else if (cmd.fin && (fin_q == FIN_RELIST)) begin
			we = 1'b1;
		end
	end

	// Page memory.
	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_s1 <= mem[raddr];
		if (we)
			mem[waddr] <= wdata;
	end

	// Sweep sequencing and page flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			scan_cnt_q <= '0;
			rv_s1      <= 1'b0;
			in_use_q   <= '0;
			listed_q   <= '0;
		end else begin
			rv_s1 <= issue;
			if (issue)
				scan_cnt_q <= scan_cnt_q + 1'b1;
			if (cmd.find_go || cmd.upd_go) begin
				scan_act_q <= 1'b1;
				scan_cnt_q <= '0;
			end else if (stat.scan_done) begin
				scan_act_q <= 1'b0;
			end
			if (cmd.fin) begin
				case (fin_q)
					FIN_NEW: begin
						in_use_q[tgt_q] <= 1'b1;
						listed_q[tgt_q] <= 1'b1;
					end
					FIN_FULL:    listed_q[tgt_q] <= 1'b0;
					FIN_RELIST:  listed_q[tgt_q] <= 1'b1;
					FIN_RELEASE: begin
						in_use_q[tgt_q] <= 1'b0;
						listed_q[tgt_q] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// Request capture, search trackers and result registers.
	always_ff @(posedge clk) begin
		ra_s1 <= scan_cnt_q[PG_W-1:0];
		if (cmd.load) begin
			act_q        <= action;
			bytes_q      <= pd_bytes;
			cached_q     <= is_cached;
			pidx_q       <= page_index;
			offs_q       <= byte_offset_in;
			res_page_q   <= '0;
			res_off_q    <= '0;
			res_rel_q    <= 1'b0;
			res_status_q <= ST_OK;
		end
		if (cmd.check) begin
			cls_q <= cls_dec;
			if (!act_q)
				res_status_q <= bypass_a ? ST_BYPASS : (invalid_a ? ST_INVALID : ST_OK);
			else
				res_status_q <= !cached_q ? ST_BYPASS : (unknown_f ? ST_UNKNOWN : ST_OK);
		end
		if (cmd.find_go) begin
			best_vld_q <= 1'b0;
			free_vld_q <= 1'b0;
			scan_find_q <= 1'b1;
		end
		if (cmd.upd_go)
			scan_find_q <= 1'b0;
		if (rv_s1 && scan_find_q) begin
			if (same_cls && (!best_vld_q || (rdata_s1.rank < best_rank_q))) begin
				best_vld_q  <= 1'b1;
				best_q      <= ra_s1;
				best_rank_q <= rdata_s1.rank;
				best_slot_q <= rdata_s1.slot;
			end
			if (!in_use_q[ra_s1] && !free_vld_q) begin
				free_vld_q <= 1'b1;
				free_q     <= ra_s1;
			end
		end
		if (cmd.pick) begin
			if (!best_vld_q) begin
				if (!free_vld_q) begin
					res_status_q <= ST_NO_PAGES;
				end else begin
					tgt_q        <= free_q;
					tgt_listed_q <= 1'b0;
					tgt_rank_q   <= '0;
					mode_q       <= UPD_LIST;
					fin_q        <= FIN_NEW;
					res_page_q   <= PIDX_W'(IXW'(free_q));
				end
			end else if (!slot_ok) begin
				res_status_q <= ST_MAP_FULL;
			end else begin
				tgt_q        <= best_q;
				tgt_listed_q <= 1'b1;
				tgt_rank_q   <= best_rank_q;
				mode_q       <= UPD_UNLIST;
				fin_q        <= FIN_FULL;
				res_page_q   <= PIDX_W'(IXW'(best_q));
				res_off_q    <= off_full[OFF_W-1:0];
			end
		end
		if (cmd.fchk) begin
			cls_q        <= rdata_s1.cls;
			tgt_q        <= pg;
			tgt_rank_q   <= rdata_s1.rank;
			tgt_listed_q <= listed_q[pg];
			tgt_slot_q   <= fslot;
			mode_q       <= fkeep ? UPD_LIST : UPD_UNLIST;
			fin_q        <= fkeep ? FIN_RELIST : FIN_RELEASE;
			res_rel_q    <= !fkeep;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.alloc     = !act_q;
		stat.early     = !act_q ? (bypass_a || invalid_a) : (!cached_q || unknown_f);
		stat.go_upd    = best_vld_q ? (slot_ok && now_full) : free_vld_q;
		stat.scan_done = scan_act_q && !issue && !rv_s1;
	end

	assign status          = res_status_q;
	assign page_out        = res_page_q;
	assign byte_offset_out = res_off_q;
	assign page_released   = res_rel_q;

	// A listed partial page is always a page in use.
	a_listed_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(listed_q & ~in_use_q) == '0)
		else $error("listed page not in use");

	// A free never reads its page while a sweep is running.
	a_no_rd_wr_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.frd |-> !scan_act_q)
		else $error("page read during sweep");

	// The sweep counter stops at the end of the page memory.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= CW'(NUM_PAGES))
		else $error("sweep counter past the last page");

endmodule

// ===== rtl/spsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsa_ctrl
// Controller: sequences check, search sweep, slot pick, page read for a free,
// rank sweep and commit for one request at a time.
// ----------------------------------------------------------------------------
module spsa_ctrl import spsa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start) state_d = S_CHECK;
			S_CHECK: begin
				if (stat.early)
					state_d = S_RESP;
				else if (stat.alloc)
					state_d = S_FIND;
				else
					state_d = S_FRD;
			end
			S_FIND:  if (stat.scan_done) state_d = S_PICK;
			S_PICK:  state_d = stat.go_upd ? S_UPD : S_RESP;
			S_FRD:   state_d = S_FCHK;
			S_FCHK:  state_d = S_UPD;
			S_UPD:   if (stat.scan_done) state_d = S_FIN;
			S_FIN:   state_d = S_RESP;
			S_RESP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_IDLE) && start;
		cmd.check   = (state_q == S_CHECK);
		cmd.find_go = (state_q == S_CHECK) && !stat.early && stat.alloc;
		cmd.pick    = (state_q == S_PICK);
		cmd.frd     = (state_q == S_FRD);
		cmd.fchk    = (state_q == S_FCHK);
		cmd.upd_go  = ((state_q == S_PICK) && stat.go_upd) || (state_q == S_FCHK);
		cmd.fin     = (state_q == S_FIN);
		busy        = (state_q != S_IDLE);
		done        = (state_q == S_RESP);
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

endmodule

// ===== rtl/subpage_slab_allocator_top.sv =====
// ----------------------------------------------------------------------------
// subpage_slab_allocator_top
// Sub-page table allocator over a pool of pages with per-page slot maps.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows,
// shown for a single cycle with done high, and the receiver cannot stall it.
// Requests refused at the check run no sweep. A free runs one rank sweep,
// and an allocation runs the search sweep and, when a page is opened or
// fills up, a rank sweep as well: each sweep walks the page memory one
// entry a cycle through its single read port.
module subpage_slab_allocator_top import spsa_pkg::*; #(
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [BYTES_W-1:0] pd_bytes,
	input  logic               is_cached,
	input  logic [PIDX_W-1:0]  page_index,
	input  logic [OFF_W-1:0]   byte_offset_in,
	output logic               done,
	output logic [2:0]         status,
	output logic [PIDX_W-1:0]  page_out,
	output logic [OFF_W-1:0]   byte_offset_out,
	output logic               page_released
);

	cmd_t  cmd;
	stat_t stat;

	spsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	spsa_dp #(
		.NUM_PAGES (NUM_PAGES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.action          (action),
		.pd_bytes        (pd_bytes),
		.is_cached       (is_cached),
		.page_index      (page_index),
		.byte_offset_in  (byte_offset_in),
		.status          (status),
		.page_out        (page_out),
		.byte_offset_out (byte_offset_out),
		.page_released   (page_released)
	);

endmodule

// ===== tb/sv/subpage_slab_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subpage_slab_allocator_top_tb
// Self-checking bench for the sub-page slab allocator. A directed table
// walks the size checks, bypass frees, unknown pages, page opening, filling
// and relisting. A random phase then follows. It is mostly well-formed
// allocations and frees of live tables, with random noise mixed in. Every
// result is checked against the table's answer or a behavioral pool model.
// ----------------------------------------------------------------------------
module subpage_slab_allocator_top_tb;
	import spsa_pkg::*;

	localparam int NPAGES    = NUM_PAGES_DEF;
	localparam int RAND_REQS = 1230;
	localparam int IDLE_MAX  = 5000;
	localparam int DRAIN     = 2 * NPAGES + 20;
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef struct {
		logic               action;
		logic [BYTES_W-1:0] bytes;
		logic               cached;
		logic [PIDX_W-1:0]  page;
		logic [OFF_W-1:0]   offs;
	} request_t;

	typedef struct {
		status_t           st;
		logic [PIDX_W-1:0] page;
		logic [OFF_W-1:0]  offs;
		logic              released;
	} answer_t;

	typedef struct {
		request_t req;
		bit       known;
		answer_t  ans;
	} dir_row_t;

	typedef struct {
		logic [PIDX_W-1:0] page;
		logic [OFF_W-1:0]  offs;
	} handle_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               action = 1'b0;
	logic [BYTES_W-1:0] pd_bytes = '0;
	logic               is_cached = 1'b0;
	logic [PIDX_W-1:0]  page_index = '0;
	logic [OFF_W-1:0]   byte_offset_in = '0;
	logic               done;
	logic [2:0]         status;
	logic [PIDX_W-1:0]  page_out;
	logic [OFF_W-1:0]   byte_offset_out;
	logic               page_released;

	// Model of the pool.
	bit                pool_used [NPAGES];
	logic [CLS_W-1:0]  pool_cls [NPAGES];
	logic [SLOT_W-1:0] pool_map [NPAGES];
	int                pool_rank [NPAGES];
	bit                pool_listed [NPAGES];

	answer_t pending_answers[$];
	handle_t live_tables[$];
	int      errors = 0;
	int      idle_cycles = 0;
	int      n_answers = 0;
	int      n_ok_alloc = 0;
	int      n_released = 0;
	int      n_no_pages = 0;

	always #2 clk = ~clk;

	subpage_slab_allocator_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .pd_bytes(pd_bytes), .is_cached(is_cached),
		.page_index(page_index), .byte_offset_in(byte_offset_in),
		.done(done), .status(status), .page_out(page_out),
		.byte_offset_out(byte_offset_out), .page_released(page_released)
	);

	function automatic logic [SLOT_W-1:0] slots_of(input int cls);
		int n;
		n = 1 << (PAGE_LOG2 - MIN_TABLE_LOG2 - cls);
		return (n >= 16) ? 16'hFFFF : SLOT_W'((1 << n) - 1);
	endfunction

	function automatic void drop_from_list(input int p);
		if (!pool_listed[p])
			return;
		for (int q = 0; q < NPAGES; q++)
			if (pool_listed[q] && q != p && pool_cls[q] == pool_cls[p] &&
			    pool_rank[q] > pool_rank[p])
				pool_rank[q]--;
		pool_listed[p] = 0;
		pool_rank[p] = 0;
	endfunction

	function automatic void list_as_newest(input int p);
		drop_from_list(p);
		for (int q = 0; q < NPAGES; q++)
			if (pool_listed[q] && pool_cls[q] == pool_cls[p])
				pool_rank[q]++;
		pool_listed[p] = 1;
		pool_rank[p] = 0;
	endfunction

	// Works out the answer to one request and updates the pool model.
	function automatic answer_t allocate_or_free(input request_t r);
		answer_t a;
		int lg, cls, best, p, bit_n;
		logic [SLOT_W-1:0] m;
		a = '{ST_OK, '0, '0, 1'b0};
		if (r.action == ACT_ALLOC) begin
			if (r.bytes >= (1 << PAGE_LOG2)) begin
				a.st = ST_BYPASS;
				return a;
			end
			if (r.bytes == 0 || (r.bytes & (r.bytes - 1)) != 0 ||
			    r.bytes < (1 << MIN_TABLE_LOG2)) begin
				a.st = ST_INVALID;
				return a;
			end
			lg = 0;
			while ((r.bytes >> lg) > 1)
				lg++;
			cls = lg - MIN_TABLE_LOG2;
			best = NPAGES;
			for (p = 0; p < NPAGES; p++)
				if (pool_listed[p] && pool_cls[p] == cls &&
				    (best == NPAGES || pool_rank[p] < pool_rank[best]))
					best = p;
			if (best == NPAGES) begin
				for (p = 0; p < NPAGES; p++)
					if (!pool_used[p])
						break;
				if (p == NPAGES) begin
					a.st = ST_NO_PAGES;
					return a;
				end
				pool_used[p] = 1;
				pool_cls[p] = CLS_W'(cls);
				pool_map[p] = 16'h0001;
				list_as_newest(p);
				a.page = PIDX_W'(p);
				return a;
			end
			m = slots_of(cls);
			for (bit_n = 0; bit_n < 16; bit_n++)
				if (!pool_map[best][bit_n])
					break;
			if (bit_n >= 16 || !m[bit_n]) begin
				a.st = ST_MAP_FULL;
				return a;
			end
			pool_map[best][bit_n] = 1'b1;
			if ((pool_map[best] & m) == m)
				drop_from_list(best);
			a.page = PIDX_W'(best);
			a.offs = OFF_W'(bit_n << lg);
			return a;
		end
		if (!r.cached) begin
			a.st = ST_BYPASS;
			return a;
		end
		p = r.page;
		if (p >= NPAGES || !pool_used[p]) begin
			a.st = ST_UNKNOWN;
			return a;
		end
		bit_n = r.offs >> (pool_cls[p] + MIN_TABLE_LOG2);
		if (bit_n < 16)
			pool_map[p][bit_n] = 1'b0;
		if ((pool_map[p] & slots_of(pool_cls[p])) != 0) begin
			list_as_newest(p);
		end else begin
			drop_from_list(p);
			pool_used[p] = 0;
			pool_map[p] = '0;
			a.released = 1'b1;
		end
		return a;
	endfunction

	// Result checker: every strobed result is matched against the oldest one due.
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			n_answers++;
			if (pending_answers.size() == 0) begin
				$error("result with nothing due: status %0d", status);
				errors++;
			end else begin
				e = pending_answers.pop_front();
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					errors++;
				end
				if (page_out !== e.page) begin
					$error("page_out: expected %0d, got %0d", e.page, page_out);
					errors++;
				end
				if (byte_offset_out !== e.offs) begin
					$error("byte_offset_out: expected %0d, got %0d",
						e.offs, byte_offset_out);
					errors++;
				end
				if (page_released !== e.released) begin
					$error("page_released: expected %0d, got %0d",
						e.released, page_released);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("watchdog expired with %0d results due", pending_answers.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Drives one request and holds it until the block takes it.
	task automatic send_request(input request_t r, input bit known, input answer_t want,
		input int gap);
		answer_t a;
		action <= r.action;
		pd_bytes <= r.bytes;
		is_cached <= r.cached;
		page_index <= r.page;
		byte_offset_in <= r.offs;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		a = allocate_or_free(r);
		if (known && (a.st != want.st || a.page != want.page ||
		    a.offs != want.offs || a.released != want.released)) begin
			$error("model disagrees with table: status %0d", a.st);
			errors++;
		end
		pending_answers.push_back(known ? want : a);
		if (a.st == ST_OK && r.action == ACT_ALLOC) begin
			n_ok_alloc++;
			live_tables.push_back('{a.page, a.offs});
		end
		if (a.released)
			n_released++;
		if (a.st == ST_NO_PAGES)
			n_no_pages++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic request_t random_request(input int i);
		request_t r;
		int pick, k, alloc_pct;
		r.action = ACT_ALLOC;
		r.bytes = BYTES_W'(1 << $urandom_range(MIN_TABLE_LOG2, PAGE_LOG2 - 1));
		r.cached = 1'b1;
		r.page = PIDX_W'($urandom);
		r.offs = OFF_W'($urandom);
		// Alternate stretches that mostly fill the pool with ones that mostly drain it.
		alloc_pct = ((i / 300) % 2 == 0) ? 80 : 30;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			// Noise: any field value at all.
			r.action = 1'($urandom_range(0, 1));
			r.bytes = BYTES_W'($urandom);
			r.cached = 1'($urandom_range(0, 1));
		end else if (pick < 12 + alloc_pct * 88 / 100 || live_tables.size() == 0) begin
			r.action = ACT_ALLOC;
		end else begin
			r.action = ACT_FREE;
			k = $urandom_range(0, live_tables.size() - 1);
			r.page = live_tables[k].page;
			r.offs = live_tables[k].offs;
			// Now and then keep the handle so it is freed twice.
			if ($urandom_range(0, 9) != 0)
				live_tables.delete(k);
		end
		return r;
	endfunction

	dir_row_t dir_rows[] = '{
		'{'{ACT_ALLOC, 16'hFFFF, 1'b0, 6'd0, 12'd0}, 1, '{ST_BYPASS, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd4096, 1'b0, 6'd0, 12'd0}, 1, '{ST_BYPASS, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd0, 1'b1, 6'd63, 12'hFFF}, 1, '{ST_INVALID, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd128, 1'b0, 6'd0, 12'd0}, 1, '{ST_INVALID, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd768, 1'b0, 6'd0, 12'd0}, 1, '{ST_INVALID, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'hFFFF, 1'b0, 6'd63, 12'hFFF}, 1, '{ST_BYPASS, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd63, 12'hFFF}, 1, '{ST_UNKNOWN, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd256, 1'b0, 6'd0, 12'd0}, 1, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd2048, 1'b0, 6'd0, 12'd0}, 1, '{ST_OK, 6'd1, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd2048, 1'b0, 6'd0, 12'd0}, 1, '{ST_OK, 6'd1, 12'd2048, 1'b0}},
		'{'{ACT_ALLOC, 16'd2048, 1'b0, 6'd0, 12'd0}, 1, '{ST_OK, 6'd2, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd512, 1'b0, 6'd0, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd1024, 1'b0, 6'd0, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd256, 1'b0, 6'd0, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd1, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd1, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_ALLOC, 16'd2048, 1'b0, 6'd0, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd2, 12'd0}, 1, '{ST_OK, 6'd0, 12'd0, 1'b1}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd2, 12'hFFF}, 1, '{ST_UNKNOWN, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd0, 12'hFFF}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd0, 12'd256}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}},
		'{'{ACT_FREE, 16'd0, 1'b1, 6'd0, 12'd0}, 0, '{ST_OK, 6'd0, 12'd0, 1'b0}}
	};

	initial begin
		request_t r;
		answer_t none;
		int gap;
		none = '{ST_OK, '0, '0, 1'b0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].ans,
				$urandom_range(0, 11));

		// Random traffic; every fourth stretch runs back to back.
		for (int i = 0; i < RAND_REQS; i++) begin
			r = random_request(i);
			gap = ((i / 100) % 4 == 3) ? 0 : $urandom_range(0, 11);
			if (i == 600) begin
				start <= 1'b0;
				while (pending_answers.size() != 0)
					@(posedge clk);
			end
			send_request(r, 0, none, gap);
		end
		start <= 1'b0;

		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Checked %0d results: %0d allocations, %0d pages released, %0d pool-full.",
			n_answers, n_ok_alloc, n_released, n_no_pages);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== subpage_slab_allocator_top.f =====
rtl/spsa_pkg.sv
rtl/spsa_dp.sv
rtl/spsa_ctrl.sv
rtl/subpage_slab_allocator_top.sv
tb/sv/subpage_slab_allocator_top_tb.sv
